@@ rtl/csc_pkg.sv @@
`default_nettype none

package csc_pkg;

   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_DQ    = 8'd34;
   localparam logic [7:0] CH_SQ    = 8'd39;
   localparam logic [7:0] CH_BT    = 8'd96;
   localparam logic [7:0] CH_BSL   = 8'd92;
   localparam logic [7:0] CH_SLASH = 8'd47;
   localparam logic [7:0] CH_STAR  = 8'd42;
   localparam logic [7:0] CH_LT    = 8'd60;
   localparam logic [7:0] CH_DASH  = 8'd45;
   localparam logic [7:0] CH_GT    = 8'd62;

   localparam logic [2:0] CLS_CODE    = 3'd0;
   localparam logic [2:0] CLS_DQ      = 3'd1;
   localparam logic [2:0] CLS_SQ      = 3'd2;
   localparam logic [2:0] CLS_BT      = 3'd3;
   localparam logic [2:0] CLS_COMMENT = 3'd4;

   // control from the window to the lexer
   typedef struct packed {
      logic fire;
      logic is_final;
   } dec_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/comment_string_classifier.sv @@
// results: a byte's result is registered once the byte two places later has been
//   accepted and the output is free, or as the window flushes after the final byte of the text
// throughput: while the output is not stalled, one byte per cycle in a steady stream, set by the
//   three-byte window feeding one decision per cycle; the final byte flushes up to three results, one per cycle
// reset: synchronous, active high; empties the window, returns the lexer to plain code
`default_nettype none

module comment_string_classifier (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_text_byte,
   input  wire logic       req_is_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic [2:0]      rsp_char_class,
   output logic            rsp_keep,
   output logic            rsp_last_out
);

   logic [7:0] win_ff [3];
   logic [7:0] win_in [3];
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic [1:0] cnt_mid;
   logic       ended_ff;
   logic       ended_in;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic [2:0] rsp_class_ff;
   logic       rsp_last_ff;

   logic       can_decide;
   logic       out_free;
   logic       req_fire;
   logic       final_byte;
   logic [7:0] next_byte;
   logic [7:0] next2_byte;
   logic [2:0] dec_class;

   csc_pkg::dec_ctrl_type ctrl;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign can_decide = (cnt_ff == 2'd3) || (ended_ff && cnt_ff != 2'd0);
   assign final_byte = ended_ff && (cnt_ff == 2'd1);
   assign req_stall  = ended_ff || ((cnt_ff == 2'd3) && !out_free);
   assign req_fire   = req_valid && !req_stall;

   assign ctrl.fire     = can_decide && out_free;
   assign ctrl.is_final = final_byte;

   // newline stands in past the end of the text
   assign next_byte  = (cnt_ff >= 2'd2) ? win_ff[1] : csc_pkg::CH_NL;
   assign next2_byte = (cnt_ff == 2'd3) ? win_ff[2] : csc_pkg::CH_NL;

   csc_lexer u_lexer (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .cur_byte   (win_ff[0]),
      .next_byte  (next_byte),
      .next2_byte (next2_byte),
      .char_class (dec_class)
   );

   always_comb begin
      win_in  = win_ff;
      cnt_mid = cnt_ff;
      if (ctrl.fire) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         cnt_mid   = cnt_ff - 2'd1;
      end
      cnt_in = cnt_mid;
      if (req_fire) begin
         case (cnt_mid)
            2'd0:    win_in[0] = req_text_byte;
            2'd1:    win_in[1] = req_text_byte;
            default: win_in[2] = req_text_byte;
         endcase
         cnt_in = cnt_mid + 2'd1;
      end

      ended_in = ended_ff;
      if (req_fire && req_is_last) begin
         ended_in = 1'b1;
      end else if (ctrl.fire && final_byte) begin
         ended_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 2'd0;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      win_ff <= win_in;
      if (ctrl.fire) begin
         rsp_byte_ff  <= win_ff[0];
         rsp_class_ff <= dec_class;
         rsp_last_ff  <= final_byte;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_char_class = rsp_class_ff;
   assign rsp_keep       = (rsp_class_ff != csc_pkg::CLS_COMMENT);
   assign rsp_last_out   = rsp_last_ff;

`ifndef SYNTHESIS
   a_ended_nonempty: assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> cnt_ff != 2'd0)
      else $error("text end flagged with an empty window");

   a_flush_done: assert property (@(posedge clock) disable iff (reset)
      (ctrl.fire && final_byte) |=> (!ended_ff && cnt_ff == 2'd0))
      else $error("window not empty after the final byte");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> cnt_ff != 2'd0)
      else $error("accepted transaction lost from the window");

   a_full_window_emits: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd3 && !rsp_stall) |=> rsp_valid)
      else $error("full window did not produce a transaction");

   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      (ctrl.fire && final_byte) |=> (rsp_valid && rsp_last_out))
      else $error("final byte result not marked last");
`endif

endmodule

`default_nettype wire

@@ rtl/csc_lexer.sv @@
`default_nettype none

module csc_lexer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire csc_pkg::dec_ctrl_type ctrl,
   input  wire logic [7:0]            cur_byte,
   input  wire logic [7:0]            next_byte,
   input  wire logic [7:0]            next2_byte,
   output logic [2:0]                 char_class
);

   typedef enum logic [2:0] {
      MODE_CODE,
      MODE_DQ,
      MODE_SQ,
      MODE_BT,
      MODE_LINE,
      MODE_BLOCK,
      MODE_TRIPLE,
      MODE_ARROW
   } mode_type;

   mode_type   mode_ff;
   mode_type   mode_in;
   logic [1:0] skip_ff;
   logic [1:0] skip_in;
   logic [7:0] prior_ff;
   logic       esc;

   assign esc = (prior_ff == csc_pkg::CH_BSL);

   always_comb begin
      mode_in    = mode_ff;
      skip_in    = skip_ff;
      char_class = csc_pkg::CLS_COMMENT;
      if (skip_ff != 2'd0) begin
         skip_in = skip_ff - 2'd1;
      end else begin
         unique case (mode_ff)
            MODE_DQ: begin
               char_class = csc_pkg::CLS_DQ;
               if (!esc && cur_byte == csc_pkg::CH_DQ) mode_in = MODE_CODE;
            end
            MODE_SQ: begin
               char_class = csc_pkg::CLS_SQ;
               if (!esc && cur_byte == csc_pkg::CH_SQ) mode_in = MODE_CODE;
            end
            MODE_BT: begin
               char_class = csc_pkg::CLS_BT;
               if (!esc && cur_byte == csc_pkg::CH_BT) mode_in = MODE_CODE;
            end
            MODE_LINE: begin
               if (cur_byte == csc_pkg::CH_NL) mode_in = MODE_CODE;
            end
            MODE_BLOCK: begin
               if (!esc && cur_byte == csc_pkg::CH_STAR && next_byte == csc_pkg::CH_SLASH) begin
                  mode_in = MODE_CODE;
                  skip_in = 2'd1;
               end
            end
            MODE_TRIPLE: begin
               if (!esc && cur_byte == csc_pkg::CH_SQ && next_byte == csc_pkg::CH_SQ
                   && next2_byte == csc_pkg::CH_SQ) begin
                  mode_in = MODE_CODE;
                  skip_in = 2'd2;
               end
            end
            MODE_ARROW: begin
               if (!esc && cur_byte == csc_pkg::CH_DASH && next_byte == csc_pkg::CH_DASH
                   && next2_byte == csc_pkg::CH_GT) begin
                  mode_in = MODE_CODE;
                  skip_in = 2'd2;
               end
            end
            MODE_CODE: begin
               // opener search, in priority order
               if (!esc && cur_byte == csc_pkg::CH_DQ) begin
                  mode_in    = MODE_DQ;
                  char_class = csc_pkg::CLS_DQ;
               end else if (!esc && cur_byte == csc_pkg::CH_SQ && next_byte != csc_pkg::CH_SQ
                            && next2_byte != csc_pkg::CH_NL) begin
                  mode_in    = MODE_SQ;
                  char_class = csc_pkg::CLS_SQ;
               end else if (!esc && cur_byte == csc_pkg::CH_BT) begin
                  mode_in    = MODE_BT;
                  char_class = csc_pkg::CLS_BT;
               end else if (cur_byte == csc_pkg::CH_SLASH && next_byte == csc_pkg::CH_SLASH) begin
                  mode_in = MODE_LINE;
                  skip_in = 2'd1;
               end else if (!esc && cur_byte == csc_pkg::CH_SLASH
                            && next_byte == csc_pkg::CH_STAR) begin
                  mode_in = MODE_BLOCK;
                  skip_in = 2'd1;
               end else if (!esc && cur_byte == csc_pkg::CH_SQ && next_byte == csc_pkg::CH_SQ
                            && next2_byte == csc_pkg::CH_SQ) begin
                  mode_in = MODE_TRIPLE;
                  skip_in = 2'd2;
               end else if (!esc && cur_byte == csc_pkg::CH_LT && next_byte == csc_pkg::CH_DASH
                            && next2_byte == csc_pkg::CH_DASH) begin
                  mode_in = MODE_ARROW;
                  skip_in = 2'd2;
               end else begin
                  char_class = csc_pkg::CLS_CODE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_CODE;
         skip_ff  <= 2'd0;
         prior_ff <= csc_pkg::CH_NL;
      end else if (ctrl.fire) begin
         if (ctrl.is_final) begin
            // end of text: back to the start-of-text state
            mode_ff  <= MODE_CODE;
            skip_ff  <= 2'd0;
            prior_ff <= csc_pkg::CH_NL;
         end else begin
            mode_ff  <= mode_in;
            skip_ff  <= skip_in;
            prior_ff <= cur_byte;
         end
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   typedef enum logic [2:0] {
      LX_CODE, LX_DQ, LX_SQ, LX_BT, LX_LINE, LX_BLOCK, LX_TRIPLE, LX_ARROW
   } lex_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] char_class;
      logic       keep;
      logic       last_out;
   } label_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_char_class;
   logic       rsp_keep;
   logic       rsp_last_out;

   lex_mode_type lx_mode;
   logic [1:0]   lx_skip;
   logic [7:0]   lx_prior;
   logic [7:0]   lx_window [2];
   int           lx_fill;

   label_type  pending_labels [$];
   logic [7:0] text_buf [$];
   bit         idle_en = 1'b1;
   int         stall_hold = 0;
   int         bytes_sent = 0;
   int         error_count = 0;

   comment_string_classifier dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_char_class (rsp_char_class),
      .rsp_keep       (rsp_keep),
      .rsp_last_out   (rsp_last_out)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("comment_string_classifier verification failed");
      $finish;
   end

   function automatic void clear_lexer();
      lx_mode      = LX_CODE;
      lx_skip      = 2'd0;
      lx_prior     = csc_pkg::CH_NL;
      lx_window[0] = 8'h00;
      lx_window[1] = 8'h00;
      lx_fill      = 0;
   endfunction

   function automatic logic [7:0] closing_quote(input lex_mode_type m);
      case (m)
         LX_DQ:   return csc_pkg::CH_DQ;
         LX_SQ:   return csc_pkg::CH_SQ;
         default: return csc_pkg::CH_BT;
      endcase
   endfunction

   // class of byte c given two bytes of lookahead, advancing the lexer
   function automatic logic [2:0] label_byte(input logic [7:0] c, n, n2);
      logic       esc;
      logic [2:0] cls;
      esc      = (lx_prior == csc_pkg::CH_BSL);
      lx_prior = c;
      if (lx_skip != 2'd0) begin
         lx_skip = lx_skip - 2'd1;
         return csc_pkg::CLS_COMMENT;
      end
      case (lx_mode)
         LX_DQ, LX_SQ, LX_BT: begin
            cls = (lx_mode == LX_DQ) ? csc_pkg::CLS_DQ :
                  (lx_mode == LX_SQ) ? csc_pkg::CLS_SQ : csc_pkg::CLS_BT;
            if (!esc && c == closing_quote(lx_mode)) lx_mode = LX_CODE;
            return cls;
         end
         LX_LINE: begin
            if (c == csc_pkg::CH_NL) lx_mode = LX_CODE;
            return csc_pkg::CLS_COMMENT;
         end
         LX_BLOCK: begin
            if (!esc && c == csc_pkg::CH_STAR && n == csc_pkg::CH_SLASH) begin
               lx_mode = LX_CODE;
               lx_skip = 2'd1;
            end
            return csc_pkg::CLS_COMMENT;
         end
         LX_TRIPLE: begin
            if (!esc && c == csc_pkg::CH_SQ && n == csc_pkg::CH_SQ
                && n2 == csc_pkg::CH_SQ) begin
               lx_mode = LX_CODE;
               lx_skip = 2'd2;
            end
            return csc_pkg::CLS_COMMENT;
         end
         LX_ARROW: begin
            if (!esc && c == csc_pkg::CH_DASH && n == csc_pkg::CH_DASH
                && n2 == csc_pkg::CH_GT) begin
               lx_mode = LX_CODE;
               lx_skip = 2'd2;
            end
            return csc_pkg::CLS_COMMENT;
         end
         default: ;
      endcase
      if (!esc && c == csc_pkg::CH_DQ) begin
         lx_mode = LX_DQ;
         return csc_pkg::CLS_DQ;
      end
      if (!esc && c == csc_pkg::CH_SQ && n != csc_pkg::CH_SQ && n2 != csc_pkg::CH_NL) begin
         lx_mode = LX_SQ;
         return csc_pkg::CLS_SQ;
      end
      if (!esc && c == csc_pkg::CH_BT) begin
         lx_mode = LX_BT;
         return csc_pkg::CLS_BT;
      end
      if (c == csc_pkg::CH_SLASH && n == csc_pkg::CH_SLASH) begin
         lx_mode = LX_LINE;
         lx_skip = 2'd1;
         return csc_pkg::CLS_COMMENT;
      end
      if (!esc && c == csc_pkg::CH_SLASH && n == csc_pkg::CH_STAR) begin
         lx_mode = LX_BLOCK;
         lx_skip = 2'd1;
         return csc_pkg::CLS_COMMENT;
      end
      if (!esc && c == csc_pkg::CH_SQ && n == csc_pkg::CH_SQ && n2 == csc_pkg::CH_SQ) begin
         lx_mode = LX_TRIPLE;
         lx_skip = 2'd2;
         return csc_pkg::CLS_COMMENT;
      end
      if (!esc && c == csc_pkg::CH_LT && n == csc_pkg::CH_DASH && n2 == csc_pkg::CH_DASH) begin
         lx_mode = LX_ARROW;
         lx_skip = 2'd2;
         return csc_pkg::CLS_COMMENT;
      end
      return csc_pkg::CLS_CODE;
   endfunction

   function automatic void push_label(input logic [7:0] b, input logic [2:0] cls,
                                      input logic last);
      pending_labels.push_back(label_type'{b, cls, cls != csc_pkg::CLS_COMMENT, last});
   endfunction

   // labels released by one accepted byte
   function automatic void predict_labels(input logic [7:0] b, input logic last);
      logic [7:0] w [3];
      logic [7:0] n;
      logic [7:0] n2;
      int         avail;
      w[0]  = lx_window[0];
      w[1]  = lx_window[1];
      w[2]  = csc_pkg::CH_NL;
      w[lx_fill] = b;
      avail = lx_fill + 1;
      if (!last) begin
         if (avail < 3) begin
            lx_window[lx_fill] = b;
            lx_fill = avail;
         end else begin
            push_label(w[0], label_byte(w[0], w[1], w[2]), 1'b0);
            lx_window[0] = w[1];
            lx_window[1] = w[2];
            lx_fill      = 2;
         end
      end else begin
         for (int k = 0; k < avail; k++) begin
            n  = (k + 1 < avail) ? w[(k + 1) % 3] : csc_pkg::CH_NL;
            n2 = (k + 2 < avail) ? w[(k + 2) % 3] : csc_pkg::CH_NL;
            push_label(w[k], label_byte(w[k], n, n2), k + 1 == avail);
         end
         clear_lexer();
      end
   endfunction

   always @(posedge clock) begin
      if (reset || !idle_en) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold == 0) begin
         rsp_stall  <= ($urandom_range(0, 2) == 0);
         stall_hold <= $urandom_range(1, 7);
      end else begin
         stall_hold <= stall_hold - 1;
      end
   end

   always @(posedge clock) begin
      label_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_labels.size() == 0) begin
            $error("unexpected transaction: out_byte %0h", rsp_out_byte);
            error_count++;
         end else begin
            exp = pending_labels.pop_front();
            if (rsp_out_byte !== exp.out_byte) begin
               $error("out_byte: expected %0h, got %0h", exp.out_byte, rsp_out_byte);
               error_count++;
            end
            if (rsp_char_class !== exp.char_class) begin
               $error("char_class: expected %0d, got %0d", exp.char_class, rsp_char_class);
               error_count++;
            end
            if (rsp_keep !== exp.keep) begin
               $error("keep: expected %0b, got %0b", exp.keep, rsp_keep);
               error_count++;
            end
            if (rsp_last_out !== exp.last_out) begin
               $error("last_out: expected %0b, got %0b", exp.last_out, rsp_last_out);
               error_count++;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_is_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_labels(b, last);
      bytes_sent++;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
   endtask

   function automatic void add_chars(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   function automatic logic [7:0] pick_special();
      case ($urandom_range(0, 9))
         0:       return csc_pkg::CH_DQ;
         1:       return csc_pkg::CH_SQ;
         2:       return csc_pkg::CH_BT;
         3:       return csc_pkg::CH_BSL;
         4:       return csc_pkg::CH_SLASH;
         5:       return csc_pkg::CH_STAR;
         6:       return csc_pkg::CH_LT;
         7:       return csc_pkg::CH_DASH;
         8:       return csc_pkg::CH_GT;
         default: return csc_pkg::CH_NL;
      endcase
   endfunction

   function automatic void add_filler(input int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 5) == 0) text_buf.push_back(pick_special());
         else text_buf.push_back(8'($urandom_range(97, 122)));
      end
   endfunction

   // mostly complete constructs with random bodies, some noise
   function automatic void add_fragment();
      case ($urandom_range(0, 14))
         0, 1: add_filler($urandom_range(1, 4));
         2: begin
            text_buf.push_back(csc_pkg::CH_DQ);
            add_filler($urandom_range(0, 4));
            text_buf.push_back(csc_pkg::CH_DQ);
         end
         3: begin
            text_buf.push_back(csc_pkg::CH_SQ);
            add_filler($urandom_range(1, 4));
            text_buf.push_back(csc_pkg::CH_SQ);
         end
         4: begin
            text_buf.push_back(csc_pkg::CH_BT);
            add_filler($urandom_range(0, 4));
            text_buf.push_back(csc_pkg::CH_BT);
         end
         5: begin
            add_chars("//");
            add_filler($urandom_range(0, 4));
            text_buf.push_back(csc_pkg::CH_NL);
         end
         6: begin
            add_chars("/*");
            add_filler($urandom_range(0, 4));
            add_chars("*/");
         end
         7: begin
            add_chars("'''");
            add_filler($urandom_range(0, 3));
            add_chars("'''");
         end
         8: begin
            add_chars("<--");
            add_filler($urandom_range(0, 3));
            add_chars("-->");
         end
         9: begin
            text_buf.push_back(csc_pkg::CH_BSL);
            text_buf.push_back(pick_special());
         end
         10: text_buf.push_back(pick_special());
         11, 12: begin
            repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(0, 255)));
         end
         default: text_buf.push_back(csc_pkg::CH_NL);
      endcase
   endfunction

   task automatic send_random_texts(input int target);
      while (bytes_sent < target) begin
         repeat ($urandom_range(1, 4)) add_fragment();
         send_text();
      end
   endtask

   task automatic test_byte_extremes();
      text_buf.push_back(8'hFF);
      send_text();
      text_buf.push_back(8'h00);
      send_text();
   endtask

   task automatic test_string_kinds();
      add_chars("\"\\\"\"");
      send_text();
      add_chars("'a'");
      send_text();
      text_buf.push_back(csc_pkg::CH_BT);
      add_chars("b");
      text_buf.push_back(csc_pkg::CH_BT);
      send_text();
   endtask

   task automatic test_comment_kinds();
      // line opener right after a backslash, then an arrow comment left open
      add_chars("\\//\n<--");
      send_text();
      add_chars("/**/'''");
      send_text();
   endtask

   task automatic test_single_quote_rules();
      add_chars("''");
      send_text();
      add_chars("'a");
      send_text();
   endtask

   task automatic test_random_texts();
      send_random_texts(190);
   endtask

   task automatic test_back_to_back();
      idle_en <= 1'b0;
      send_random_texts(225);
   endtask

   initial begin
      clear_lexer();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_byte_extremes();
      test_string_kinds();
      test_comment_kinds();
      test_single_quote_rules();
      test_random_texts();
      test_back_to_back();
      req_valid <= 1'b0;
      while (pending_labels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("comment_string_classifier verification clean");
      end else begin
         $display("comment_string_classifier verification failed");
      end
      $finish;
   end

endmodule

@@ comment_string_classifier.f @@
rtl/csc_pkg.sv
rtl/csc_lexer.sv
rtl/comment_string_classifier.sv
tb/sv/tb_top.sv
